### rtl/rhr_pkg.sv
package rhr_pkg;

  localparam int HISTORY_DEPTH = 16;
  localparam int ID_WIDTH      = 16;

  // widths fixed by the interface fields
  localparam int CNT_W = 5;
  localparam int OP_W  = 2;

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  localparam logic [CNT_W-1:0] CAP_RESET =
    (16 > HISTORY_DEPTH) ? CNT_W'(HISTORY_DEPTH) : CNT_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_CHECK  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic                found;
    logic                removed_valid;
    logic [ID_WIDTH-1:0] removed_id;
    logic [CNT_W-1:0]    entry_count;
  } rhr_result_t;

  typedef struct packed {
    logic                we;
    logic [PTR_W-1:0]    waddr;
    logic [ID_WIDTH-1:0] wdata;
    logic [PTR_W-1:0]    raddr;
  } rhr_ram_req_t;

endpackage

### rtl/recent_history_ring_top.sv
// Add, empty remove, zero lookback and unused op: finished in the exec state, then out_valid.
// Remove: exec, then pop. Check: exec, then a scan over lookback' = min(lookback, entries
// held), one comparator reading one history entry a cycle; a hit ends the scan early.
// A new transfer is taken only once the result is out; busy stays high while an item is in work.
// Results are strobed one cycle on out_valid; the receiver cannot stall.
// Reset (sync, rst_n low): history empty, capacity 16; a cfg write also empties it.
module recent_history_ring_top
  import rhr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     in_op,
  input  logic [ID_WIDTH-1:0] in_item_id,
  input  logic [CNT_W-1:0]    in_lookback,
  output logic                out_valid,
  output logic                out_found,
  output logic                out_removed_valid,
  output logic [ID_WIDTH-1:0] out_removed_id,
  output logic [CNT_W-1:0]    out_entry_count,
  input  logic                cfg_we,
  input  logic [CNT_W-1:0]    cfg_wdata
);

  logic [CNT_W-1:0]    cap_r, cap_nxt;
  rhr_ram_req_t        ram_req;
  logic [ID_WIDTH-1:0] ram_rdata;
  logic                accept;
  rhr_result_t         result;

  assign accept = start && !busy;

  // capacity saturates to 1..HISTORY_DEPTH
  always_comb begin
    cap_nxt = cap_r;
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        cap_nxt = CNT_W'(1);
      end else if (cfg_wdata > CNT_W'(HISTORY_DEPTH)) begin
        cap_nxt = CNT_W'(HISTORY_DEPTH);
      end else begin
        cap_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  rhr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .op        (in_op),
    .item_id   (in_item_id),
    .lookback  (in_lookback),
    .clear     (cfg_we),
    .capacity  (cap_r),
    .ram_rdata (ram_rdata),
    .ram_req   (ram_req),
    .busy      (busy),
    .done      (out_valid),
    .result    (result)
  );

  rhr_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (HISTORY_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  assign out_found         = result.found;
  assign out_removed_valid = result.removed_valid;
  assign out_removed_id    = result.removed_id;
  assign out_entry_count   = result.entry_count;

endmodule

### rtl/rhr_ram.sv
module rhr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/rhr_ctrl.sv
module rhr_ctrl
  import rhr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [OP_W-1:0]     op,
  input  logic [ID_WIDTH-1:0] item_id,
  input  logic [CNT_W-1:0]    lookback,
  input  logic                clear,
  input  logic [CNT_W-1:0]    capacity,
  input  logic [ID_WIDTH-1:0] ram_rdata,
  output rhr_ram_req_t        ram_req,
  output logic                busy,
  output logic                done,
  output rhr_result_t         result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_POP
  } state_t;

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [ID_WIDTH-1:0] id_r, id_nxt;
  logic [CNT_W-1:0]    look_r, look_nxt;
  logic [PTR_W-1:0]    oldest_r, oldest_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    off_r, off_nxt;
  logic [CNT_W-1:0]    remain_r, remain_nxt;
  logic                pend_r, pend_nxt;
  logic                done_r, done_nxt;
  rhr_result_t         res_r, res_nxt;

  // shared slot unit: (oldest + offset) mod capacity, sum stays below 2*capacity for each slot whose data is used
  logic [CNT_W-1:0] off_sel;
  logic [CNT_W:0]   slot_sum;
  logic [CNT_W:0]   slot_mod;
  logic [CNT_W-1:0] look_eff;
  logic [PTR_W-1:0] oldest_inc;
  logic             hit;

  assign slot_sum = {1'b0, CNT_W'(oldest_r)} + {1'b0, off_sel};
  assign slot_mod = (slot_sum >= {1'b0, capacity}) ? slot_sum - {1'b0, capacity} : slot_sum;
  assign look_eff = (look_r > count_r) ? count_r : look_r;
  assign oldest_inc = ({1'b0, CNT_W'(oldest_r)} + 1'b1 == {1'b0, capacity}) ?
                      '0 : oldest_r + 1'b1;
  assign hit = (ram_rdata == id_r);

  always_comb begin
    off_sel = off_r;
    if (state_r == S_EXEC) begin
      off_sel = (op_r == OP_ADD) ? count_r : count_r - 1'b1;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    id_nxt     = id_r;
    look_nxt   = look_r;
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    off_nxt    = off_r;
    remain_nxt = remain_r;
    pend_nxt   = 1'b0;
    done_nxt   = 1'b0;
    res_nxt    = res_r;
    ram_req.we    = 1'b0;
    ram_req.waddr = slot_mod[PTR_W-1:0];
    ram_req.wdata = id_r;
    ram_req.raddr = slot_mod[PTR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = op_t'(op);
          id_nxt    = item_id;
          look_nxt  = lookback;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt             = '0;
        res_nxt.entry_count = count_r;
        case (op_r)
          OP_ADD: begin
            ram_req.we = 1'b1;
            if (count_r < capacity) begin
              count_nxt = count_r + 1'b1;
            end else begin
              oldest_nxt = oldest_inc;
            end
            res_nxt.entry_count = (count_r < capacity) ? count_r + 1'b1 : count_r;
            done_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
          OP_CHECK: begin
            if (look_eff == '0) begin
              done_nxt  = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              off_nxt    = count_r - 1'b1;
              remain_nxt = look_eff;
              state_nxt  = S_SCAN;
            end
          end
          OP_REMOVE: begin
            if (count_r == '0) begin
              done_nxt  = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_POP;
            end
          end
          default: begin
            done_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        // issue one read a cycle, compare the previous one's data
        if (pend_r && hit) begin
          res_nxt.found = 1'b1;
          done_nxt      = 1'b1;
          state_nxt     = S_IDLE;
        end else if (remain_r != '0) begin
          off_nxt    = off_r - 1'b1;
          remain_nxt = remain_r - 1'b1;
          pend_nxt   = 1'b1;
        end else begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_POP: begin
        count_nxt             = count_r - 1'b1;
        res_nxt.removed_valid = 1'b1;
        res_nxt.removed_id    = ram_rdata;
        res_nxt.entry_count   = count_r - 1'b1;
        done_nxt              = 1'b1;
        state_nxt             = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (clear) begin
      oldest_nxt = '0;
      count_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      oldest_r <= '0;
      count_r  <= '0;
      pend_r   <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      pend_r   <= pend_nxt;
      done_r   <= done_nxt;
    end
    op_r     <= op_nxt;
    id_r     <= id_nxt;
    look_r   <= look_nxt;
    off_r    <= off_nxt;
    remain_r <= remain_nxt;
    res_r    <= res_nxt;
  end

  assign busy   = (state_r != S_IDLE);
  assign done   = done_r;
  assign result = res_r;

endmodule

### rtl/rhr_checker.sv
module rhr_checker
  import rhr_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic                out_found,
  input logic                out_removed_valid,
  input logic [ID_WIDTH-1:0] out_removed_id,
  input logic [CNT_W-1:0]    out_entry_count
);

  a_take_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after a transfer");

  a_result_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_removed_valid))
    else $error("found and removed_valid both set");

  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_removed_valid |-> out_removed_id == '0)
    else $error("removed_id nonzero without a pop");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CNT_W'(HISTORY_DEPTH))
    else $error("entry_count above history depth");

endmodule

bind recent_history_ring_top rhr_checker u_rhr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_found         (out_found),
  .out_removed_valid (out_removed_valid),
  .out_removed_id    (out_removed_id),
  .out_entry_count   (out_entry_count)
);
